// ===== hw/rtl/b2a_pkg.sv =====
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants for the binary to ASCII formatter
// Holds the format codes, the digit cell geometry, the word handed from the
// converter to the character emitter, and the nibble to ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

	// Format codes carried on the command field.
	localparam int unsigned CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_HEX8  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HEX16 = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HEX32 = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEC16 = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEC32 = 3'd4;

	// Word and digit geometry.
	localparam int unsigned VALUE_W       = 32;
	localparam int unsigned CHAR_W        = 7;
	localparam int unsigned DIGIT_W       = 4;
	localparam int unsigned NUM_DIGITS    = 10;
	localparam int unsigned HEX_DIGITS    = VALUE_W / DIGIT_W;
	localparam int unsigned POS_W         = $clog2(NUM_DIGITS);
	localparam int unsigned BITS_PER_STEP = 4;
	localparam int unsigned STEP_W        = 4;

	// Conversion lengths in cycles, four value bits per cycle.
	localparam logic [STEP_W-1:0] DEC16_STEPS = STEP_W'(16 / BITS_PER_STEP);
	localparam logic [STEP_W-1:0] DEC32_STEPS = STEP_W'(32 / BITS_PER_STEP);

	// Most significant digit positions of the hex formats.
	localparam logic [POS_W-1:0] HEX8_MSD  = POS_W'(1);
	localparam logic [POS_W-1:0] HEX16_MSD = POS_W'(3);
	localparam logic [POS_W-1:0] HEX32_MSD = POS_W'(7);

	// Add-three threshold and addend of the cells, and the first letter digit.
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'h0a;

	// ASCII anchors.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;

	// Finished digits handed from the converter to the emitter.
	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
		logic [POS_W-1:0]                   msd;
	} conv_word_t;

	// One digit, decimal or hex, as a lowercase ASCII character.
	function automatic logic [CHAR_W-1:0] nibble_to_ascii(input logic [DIGIT_W-1:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
		if (nib < DIGIT_TEN) begin
			return ASCII_ZERO + wide;
		end else begin
			return ASCII_A + wide - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b2a_cell.sv =====
// ----------------------------------------------------------------------------
// b2a_cell: one decimal digit cell of the shift-and-add-three chain
// Holds one digit and, while shift is high, takes four bits a cycle from
// its lower neighbour, passing the bits it shifts out on to the higher one.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_cell
	import b2a_pkg::*;
(
	input  logic                     clk,
	input  logic                     load,
	input  logic [DIGIT_W-1:0]       load_digit,
	input  logic                     shift,
	input  logic [BITS_PER_STEP-1:0] bits_in,
	output logic [BITS_PER_STEP-1:0] bits_out,
	output logic [DIGIT_W-1:0]       digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] work;
	logic [DIGIT_W-1:0] adj;
	logic [DIGIT_W-1:0] next_digit;

	// Four correction-and-shift steps; bit j goes out before bit j enters.
	always_comb begin
		work     = digit_q;
		adj      = digit_q;
		bits_out = '0;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			bits_out[j] = (work >= DIGIT_FIVE);
			adj         = bits_out[j] ? work + DIGIT_THREE : work;
			work        = {adj[DIGIT_W-2:0], bits_in[j]};
		end
		next_digit = work;
	end

	// The digit is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			digit_q <= load_digit;
		end else if (shift) begin
			digit_q <= next_digit;
		end
	end

	assign digit = digit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/b2a_conv.sv =====
// ----------------------------------------------------------------------------
// b2a_conv: format decode and binary to decimal conversion
// Loads hex nibbles straight into the digit cells, or clears them and shifts
// the value in four bits a cycle for the decimal formats, then holds the
// finished word until the emitter takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_conv
	import b2a_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [VALUE_W-1:0] value,
	output logic               word_valid,
	input  logic               word_ready,
	output conv_word_t         word
);

	logic                     busy_q;
	logic [STEP_W-1:0]        steps_q;
	logic                     hex_q;
	logic [POS_W-1:0]         hex_msd_q;
	logic [VALUE_W-1:0]       bin_q;

	logic                     accept;
	logic                     handoff;
	logic                     shift;
	logic                     cmd_ok;
	logic                     cmd_hex;
	logic [STEP_W-1:0]        cmd_steps;
	logic [POS_W-1:0]         cmd_msd;
	logic [VALUE_W-1:0]       hex_value;
	logic [VALUE_W-1:0]       bin_load;
	logic [POS_W-1:0]         dec_msd;

	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]       load_digits;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]       cell_digits;
	logic [NUM_DIGITS-1:0][BITS_PER_STEP-1:0] cell_in;
	logic [NUM_DIGITS-1:0][BITS_PER_STEP-1:0] cell_out;

	// Handshake: a new word may enter as the finished one leaves.
	assign word_valid = busy_q && (steps_q == '0);
	assign handoff    = word_valid && word_ready;
	assign in_ready   = !busy_q || handoff;
	assign accept     = in_valid && in_ready;
	assign shift      = busy_q && (steps_q != '0);

	// Command decode: masking, conversion length and hex digit count.
	always_comb begin
		cmd_ok    = 1'b1;
		cmd_hex   = 1'b1;
		cmd_steps = '0;
		cmd_msd   = HEX32_MSD;
		hex_value = value;
		bin_load  = value;
		unique case (command)
			CMD_HEX8: begin
				cmd_msd   = HEX8_MSD;
				hex_value = {24'h0, value[7:0]};
			end
			CMD_HEX16: begin
				cmd_msd   = HEX16_MSD;
				hex_value = {16'h0, value[15:0]};
			end
			CMD_HEX32: begin
				cmd_msd = HEX32_MSD;
			end
			CMD_DEC16: begin
				cmd_hex   = 1'b0;
				cmd_steps = DEC16_STEPS;
				hex_value = '0;
				bin_load  = {value[15:0], 16'h0};
			end
			CMD_DEC32: begin
				cmd_hex   = 1'b0;
				cmd_steps = DEC32_STEPS;
				hex_value = '0;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// Load values for the cells: hex nibbles, or zero ahead of a conversion.
	always_comb begin
		load_digits                 = '0;
		load_digits[HEX_DIGITS-1:0] = hex_value;
	end

	// The lowest cell takes the value bits most significant first.
	always_comb begin
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			cell_in[0][j] = bin_q[VALUE_W-1-j];
		end
		for (int i = 1; i < NUM_DIGITS; i++) begin
			cell_in[i] = cell_out[i-1];
		end
	end

	// The row of digit cells; the top cell never carries out, so its
	// outgoing bits are not used.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		b2a_cell u_cell (
			.clk        (clk),
			.load       (accept),
			.load_digit (load_digits[i]),
			.shift      (shift),
			.bits_in    (cell_in[i]),
			.bits_out   (cell_out[i]),
			.digit      (cell_digits[i])
		);
	end

	// Control state of the converter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			steps_q   <= '0;
			hex_q     <= 1'b0;
			hex_msd_q <= '0;
		end else begin
			priority if (accept) begin
				busy_q    <= cmd_ok;
				steps_q   <= cmd_steps;
				hex_q     <= cmd_hex;
				hex_msd_q <= cmd_msd;
			end else if (handoff) begin
				busy_q <= 1'b0;
			end else if (shift) begin
				steps_q <= steps_q - STEP_W'(1);
			end
		end
	end

	// Value shift register feeding the lowest cell.
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= bin_load;
		end else if (shift) begin
			bin_q <= {bin_q[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
		end
	end

	// Highest non-zero decimal digit; zero still shows one digit.
	always_comb begin
		dec_msd = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (cell_digits[i] != '0) begin
				dec_msd = POS_W'(i);
			end
		end
	end

	assign word.digits = cell_digits;
	assign word.msd    = hex_q ? hex_msd_q : dec_msd;

endmodule

`default_nettype wire

// ===== hw/rtl/b2a_emit.sv =====
// ----------------------------------------------------------------------------
// b2a_emit: character emitter
// Holds one finished word and sends its digits as ASCII, most significant
// first, marking the last, and takes the next word as the last one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_emit
	import b2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              word_valid,
	output logic              word_ready,
	input  conv_word_t        word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	logic                               active_q;
	logic [POS_W-1:0]                   pos_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic                               load;
	logic                               send;

	assign send       = active_q && out_ready;
	assign word_ready = !active_q || (send && (pos_q == '0));
	assign load       = word_valid && word_ready;

	// Position counts down from the leading digit to the units digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			priority if (load) begin
				active_q <= 1'b1;
				pos_q    <= word.msd;
			end else if (send) begin
				if (pos_q == '0) begin
					active_q <= 1'b0;
				end else begin
					pos_q <= pos_q - POS_W'(1);
				end
			end
		end
	end

	// Digit store is payload.
	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= word.digits;
		end
	end

	assign out_valid = active_q;
	assign character = nibble_to_ascii(digits_q[pos_q]);
	assign last      = (pos_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/binary_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// binary_to_ascii_formatter: unsigned value to ASCII hex or decimal digits
// Formats one value per input word as 2, 4 or 8 hex digits or as decimal
// digits without leading zeros, one character per output word.
//
//   channel  signals                          word
//   input    in_valid / in_ready              command, value
//   output   out_valid / out_ready            character, last
//
// A hex word is ready for the emitter in the cycle after it is taken; a decimal
// word first passes through the digit cell chain, which shifts four value bits a
// cycle. Characters then leave at one per cycle while out_ready is high, and the
// next word converts meanwhile.
// Reset clears the control state only; no clearing pass is needed.
// A stalled output holds the emitter, the converter then holds its finished
// word, and the input waits.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_ascii_formatter
	import b2a_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  character,
	output logic               last
);

	logic       word_valid;
	logic       word_ready;
	conv_word_t word;

	// Decode and conversion through the digit cells.
	b2a_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.value      (value),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word)
	);

	// Character output.
	b2a_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last)
	);

	// The leading digit position always lies inside the digit row.
	a_msd_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (word.msd <= POS_W'(NUM_DIGITS - 1)))
		else $error("leading digit position out of range");

	// A finished word waiting for the emitter does not change.
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(word))
		else $error("finished word changed while waiting");

	// A word handed to the emitter shows up on the output next cycle.
	a_handoff_out: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready |=> out_valid)
		else $error("handed-off word did not reach the output");

	// An unused command produces no word.
	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command > CMD_DEC32) |=> !word_valid)
		else $error("unused command produced a word");

endmodule

`default_nettype wire
